[hdl/i2cmw_pkg.sv]
package i2cmw_pkg;

	localparam int TICK_WIDTH_DEF = 16;
	localparam int PHASE_TICKS_W  = 16;
	localparam int BYTE_W         = 8;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 1;

	localparam logic [BYTE_W-1:0]        ADDRESS_BYTE_RST = 8'd120;
	localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RST  = 16'd90;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ADDRESS_BYTE = 1'b0,
		REG_PHASE_TICKS  = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_BIT   = 3'd2,
		PH_ACK   = 3'd3,
		PH_STOP  = 3'd4
	} bus_phase_t;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_PROBE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		BYTE_ADDR = 2'd0,
		BYTE_REG  = 2'd1,
		BYTE_DATA = 2'd2
	} byte_sel_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic       nack;
		logic [1:0] failed_byte;
	} res_t;

endpackage

[hdl/i2cmw_item_if.sv]
interface i2cmw_item_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic                           go;
	logic [i2cmw_pkg::BYTE_W-1:0]   reg_byte;
	logic [i2cmw_pkg::BYTE_W-1:0]   data_byte;
	logic                           sda_in;

	modport source (output valid, output op, output go, output reg_byte, output data_byte,
		output sda_in, input ready);
	modport sink (input valid, input op, input go, input reg_byte, input data_byte,
		input sda_in, output ready);
endinterface

[hdl/i2cmw_res_if.sv]
interface i2cmw_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic       nack;
	logic [1:0] failed_byte;

	modport source (output valid, output scl_out, output sda_out, output busy_res,
		output done_res, output nack, output failed_byte, input ready);
	modport sink (input valid, input scl_out, input sda_out, input busy_res,
		input done_res, input nack, input failed_byte, output ready);
endinterface

[hdl/i2c_master_register_write_core.sv]
// I2C master for register writes and address probes. Each accepted item is one tick of the bus
// timer: the bus state advances by one tick and one result item (pin drives and status) comes
// back, registered. One item is accepted every cycle while the skid entry is empty; a two-entry
// output buffer lets one more item in while the result side stalls. A go while idle
// starts a transaction: start, address byte, then register and data bytes (write) or nothing
// more (probe), each byte followed by an acknowledge sample; a NACK goes straight to stop.
// Each bus phase step lasts phase_ticks ticks (0 acts as 1, clipped to what TICK_WIDTH holds).
// done_res pulses on the tick the stop completes, with nack and failed_byte.
module i2c_master_register_write_core #(
	parameter int TICK_WIDTH = i2cmw_pkg::TICK_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	i2cmw_item_if.sink                          item,
	i2cmw_res_if.source                         result,
	input  logic                                cfg_we,
	input  logic [i2cmw_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [i2cmw_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = (TICK_WIDTH > i2cmw_pkg::PHASE_TICKS_W) ?
		TICK_WIDTH : i2cmw_pkg::PHASE_TICKS_W;
	localparam int BW = i2cmw_pkg::BYTE_W;

	// configuration
	logic [BW-1:0]                          address_byte_q;
	logic [i2cmw_pkg::PHASE_TICKS_W-1:0]    phase_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_byte_q <= i2cmw_pkg::ADDRESS_BYTE_RST;
			phase_ticks_q  <= i2cmw_pkg::PHASE_TICKS_RST;
		end else if (cfg_we) begin
			case (i2cmw_pkg::cfg_reg_t'(cfg_index))
				i2cmw_pkg::REG_ADDRESS_BYTE: address_byte_q <= cfg_data[BW-1:0];
				i2cmw_pkg::REG_PHASE_TICKS:
					phase_ticks_q <= cfg_data[i2cmw_pkg::PHASE_TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// bus state
	i2cmw_pkg::bus_phase_t  phase_q, phase_d;
	logic [1:0]             sub_q, sub_d;
	logic [TICK_WIDTH-1:0]  tick_q, tick_d;
	logic [2:0]             bit_q, bit_d;
	logic [1:0]             byte_q, byte_d;
	logic [BW-1:0]          shift_q, shift_d;
	logic [BW-1:0]          held_reg_q, held_reg_d;
	logic [BW-1:0]          held_data_q, held_data_d;
	logic                   probe_q, probe_d;
	logic                   scl_q, scl_d;
	logic                   sda_q, sda_d;
	logic                   nack_q, nack_d;
	logic                   done_d;

	logic [CW-1:0]          cap_w, ticks_w, limit_w;
	logic [TICK_WIDTH-1:0]  limit;
	logic                   accept;
	i2cmw_pkg::res_t        res_d;

	assign accept = item.valid && item.ready;

	always_comb begin
		cap_w   = CW'({TICK_WIDTH{1'b1}});
		ticks_w = CW'(phase_ticks_q);
		limit_w = (ticks_w > cap_w) ? cap_w : ticks_w;
		if (limit_w == '0) begin
			limit_w = CW'(1);
		end
		limit = limit_w[TICK_WIDTH-1:0];
	end

	always_comb begin
		phase_d     = phase_q;
		sub_d       = sub_q;
		tick_d      = tick_q;
		bit_d       = bit_q;
		byte_d      = byte_q;
		shift_d     = shift_q;
		held_reg_d  = held_reg_q;
		held_data_d = held_data_q;
		probe_d     = probe_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		nack_d      = nack_q;
		done_d      = 1'b0;

		if (phase_q == i2cmw_pkg::PH_IDLE) begin
			if (item.go) begin
				probe_d     = item.op;
				held_reg_d  = item.reg_byte;
				held_data_d = item.data_byte;
				shift_d     = address_byte_q;
				byte_d      = i2cmw_pkg::BYTE_ADDR;
				bit_d       = '0;
				nack_d      = 1'b0;
				phase_d     = i2cmw_pkg::PH_START;
				sub_d       = '0;
				scl_d       = 1'b1;
				sda_d       = 1'b1;
				tick_d      = TICK_WIDTH'(1);
			end
		end else if (tick_q < limit) begin
			tick_d = tick_q + TICK_WIDTH'(1);
		end else begin
			tick_d = TICK_WIDTH'(1);
			case (phase_q)
				i2cmw_pkg::PH_START: begin
					if (sub_q == 2'd0) begin
						sda_d = 1'b0;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						scl_d = 1'b0;
						sub_d = 2'd2;
					end else begin
						bit_d   = '0;
						phase_d = i2cmw_pkg::PH_BIT;
						sub_d   = '0;
						sda_d   = shift_q[BW-1];
					end
				end
				i2cmw_pkg::PH_BIT: begin
					if (sub_q == 2'd0) begin
						scl_d = 1'b1;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						scl_d = 1'b0;
						if (bit_q == 3'd7) begin
							sda_d = 1'b1;
						end
						shift_d = {shift_q[BW-2:0], 1'b0};
						sub_d   = 2'd2;
					end else if (bit_q == 3'd7) begin
						// release SDA for the slave's acknowledge
						phase_d = i2cmw_pkg::PH_ACK;
						sub_d   = '0;
						sda_d   = 1'b1;
					end else begin
						bit_d   = bit_q + 3'd1;
						phase_d = i2cmw_pkg::PH_BIT;
						sub_d   = '0;
						sda_d   = shift_q[BW-1];
					end
				end
				i2cmw_pkg::PH_ACK: begin
					if (sub_q == 2'd0) begin
						scl_d = 1'b1;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						nack_d = item.sda_in;
						scl_d  = 1'b0;
						sub_d  = 2'd2;
					end else if (nack_q || probe_q || byte_q >= i2cmw_pkg::BYTE_DATA) begin
						phase_d = i2cmw_pkg::PH_STOP;
						sub_d   = '0;
						sda_d   = 1'b0;
						scl_d   = 1'b1;
					end else begin
						byte_d  = byte_q + 2'd1;
						shift_d = (byte_q == i2cmw_pkg::BYTE_ADDR) ? held_reg_q : held_data_q;
						bit_d   = '0;
						phase_d = i2cmw_pkg::PH_BIT;
						sub_d   = '0;
						sda_d   = shift_d[BW-1];
					end
				end
				i2cmw_pkg::PH_STOP: begin
					sda_d   = 1'b1;
					scl_d   = 1'b1;
					phase_d = i2cmw_pkg::PH_IDLE;
					sub_d   = '0;
					tick_d  = '0;
					done_d  = 1'b1;
				end
				default: begin
					phase_d = i2cmw_pkg::PH_IDLE;
					sub_d   = '0;
					tick_d  = '0;
					scl_d   = 1'b1;
					sda_d   = 1'b1;
				end
			endcase
		end

		res_d.scl_out     = scl_d;
		res_d.sda_out     = sda_d;
		res_d.busy_res    = (phase_d != i2cmw_pkg::PH_IDLE);
		res_d.done_res    = done_d;
		res_d.nack        = done_d && nack_d;
		res_d.failed_byte = (done_d && nack_d) ? byte_d : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cmw_pkg::PH_IDLE;
			sub_q       <= '0;
			tick_q      <= '0;
			bit_q       <= '0;
			byte_q      <= '0;
			shift_q     <= '0;
			held_reg_q  <= '0;
			held_data_q <= '0;
			probe_q     <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			nack_q      <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			sub_q       <= sub_d;
			tick_q      <= tick_d;
			bit_q       <= bit_d;
			byte_q      <= byte_d;
			shift_q     <= shift_d;
			held_reg_q  <= held_reg_d;
			held_data_q <= held_data_d;
			probe_q     <= probe_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			nack_q      <= nack_d;
		end
	end

	// two-entry result buffer: output register plus skid
	logic               out_valid_q, skid_valid_q;
	i2cmw_pkg::res_t    out_q, skid_q;
	logic               pop;

	assign item.ready = !skid_valid_q;
	assign pop        = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res_d;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.scl_out     = out_q.scl_out;
	assign result.sda_out     = out_q.sda_out;
	assign result.busy_res    = out_q.busy_res;
	assign result.done_res    = out_q.done_res;
	assign result.nack        = out_q.nack;
	assign result.failed_byte = out_q.failed_byte;

endmodule

[hdl/i2cmw_checker.sv]
module i2cmw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       scl_out,
	input logic       sda_out,
	input logic       busy_res,
	input logic       done_res,
	input logic       nack,
	input logic [1:0] failed_byte
);

	// stop completes into idle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// idle bus has both lines released
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !busy_res |-> scl_out && sda_out)
		else $error("bus line held low while idle");

	// failure info only rides on a done with nack
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (nack || failed_byte != 2'd0) |-> done_res && nack && failed_byte != 2'd3)
		else $error("bad nack or failed_byte report");

	// stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable({scl_out, sda_out, busy_res,
			done_res, nack, failed_byte}))
		else $error("result changed while stalled");

endmodule

bind i2c_master_register_write_core i2cmw_checker u_i2cmw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.scl_out     (result.scl_out),
	.sda_out     (result.sda_out),
	.busy_res    (result.busy_res),
	.done_res    (result.done_res),
	.nack        (result.nack),
	.failed_byte (result.failed_byte)
);

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

	localparam logic [1:0] NO_NACK = 2'd3;

	// Tick-accurate model of the bus engine plus the queue of pending result items.
	class i2c_bus_scoreboard;
		logic [7:0]  addr_cfg  = i2cmw_pkg::ADDRESS_BYTE_RST;
		logic [15:0] ticks_cfg = i2cmw_pkg::PHASE_TICKS_RST;

		i2cmw_pkg::bus_phase_t phase = i2cmw_pkg::PH_IDLE;
		logic [1:0]  beat      = 2'd0;
		logic [15:0] tick_cnt  = 16'd0;
		logic [2:0]  bit_cnt   = 3'd0;
		logic [1:0]  byte_sel  = i2cmw_pkg::BYTE_ADDR;
		logic [7:0]  shifter   = 8'd0;
		logic [7:0]  held_reg  = 8'd0;
		logic [7:0]  held_data = 8'd0;
		i2cmw_pkg::op_t mode   = i2cmw_pkg::OP_WRITE;
		logic        scl       = 1'b1;
		logic        sda       = 1'b1;
		logic        nack_hit  = 1'b0;

		i2cmw_pkg::res_t bus_levels_q[$];
		int          errors    = 0;

		function void write_reg(i2cmw_pkg::cfg_reg_t idx, logic [15:0] v);
			case (idx)
				i2cmw_pkg::REG_ADDRESS_BYTE: addr_cfg = v[7:0];
				i2cmw_pkg::REG_PHASE_TICKS:  ticks_cfg = v;
				default: ;
			endcase
		endfunction

		// With TICK_WIDTH at 16 the register can never exceed the counter, so no clipping.
		function logic [15:0] phase_len();
			return (ticks_cfg == 16'd0) ? 16'd1 : ticks_cfg;
		endfunction

		function bit idle();
			return phase == i2cmw_pkg::PH_IDLE;
		endfunction

		function bit at_boundary();
			return (phase != i2cmw_pkg::PH_IDLE) && (tick_cnt >= phase_len());
		endfunction

		// next accepted tick samples the acknowledge
		function bit ack_next();
			return at_boundary() && (phase == i2cmw_pkg::PH_ACK) && (beat == 2'd1);
		endfunction

		function bit done_next();
			return at_boundary() && (phase == i2cmw_pkg::PH_STOP);
		endfunction

		function int pending();
			return bus_levels_q.size();
		endfunction

		function void start_bit();
			phase = i2cmw_pkg::PH_BIT;
			beat  = 2'd0;
			sda   = shifter[7];
		endfunction

		function void advance_phase(logic sda_sample, output logic done);
			done = 1'b0;
			case (phase)
				i2cmw_pkg::PH_START: begin
					if (beat == 2'd0) begin
						sda  = 1'b0;
						beat = 2'd1;
					end else if (beat == 2'd1) begin
						scl  = 1'b0;
						beat = 2'd2;
					end else begin
						bit_cnt = 3'd0;
						start_bit();
					end
				end
				i2cmw_pkg::PH_BIT: begin
					if (beat == 2'd0) begin
						scl  = 1'b1;
						beat = 2'd1;
					end else if (beat == 2'd1) begin
						scl = 1'b0;
						if (bit_cnt == 3'd7)
							sda = 1'b1;
						shifter = shifter << 1;
						beat    = 2'd2;
					end else if (bit_cnt == 3'd7) begin
						phase = i2cmw_pkg::PH_ACK;
						beat  = 2'd0;
						sda   = 1'b1;
					end else begin
						bit_cnt = bit_cnt + 3'd1;
						start_bit();
					end
				end
				i2cmw_pkg::PH_ACK: begin
					if (beat == 2'd0) begin
						scl  = 1'b1;
						beat = 2'd1;
					end else if (beat == 2'd1) begin
						nack_hit = sda_sample;
						scl      = 1'b0;
						beat     = 2'd2;
					end else if (nack_hit || mode == i2cmw_pkg::OP_PROBE ||
					    byte_sel >= i2cmw_pkg::BYTE_DATA) begin
						phase = i2cmw_pkg::PH_STOP;
						beat  = 2'd0;
						sda   = 1'b0;
						scl   = 1'b1;
					end else begin
						byte_sel = byte_sel + 2'd1;
						shifter  = (byte_sel == i2cmw_pkg::BYTE_REG) ? held_reg : held_data;
						bit_cnt  = 3'd0;
						start_bit();
					end
				end
				i2cmw_pkg::PH_STOP: begin
					sda      = 1'b1;
					scl      = 1'b1;
					phase    = i2cmw_pkg::PH_IDLE;
					beat     = 2'd0;
					tick_cnt = 16'd0;
					done     = 1'b1;
				end
				default: begin
					phase    = i2cmw_pkg::PH_IDLE;
					beat     = 2'd0;
					tick_cnt = 16'd0;
					scl      = 1'b1;
					sda      = 1'b1;
				end
			endcase
		endfunction

		function void note_tick(i2cmw_pkg::op_t o, logic g, logic [7:0] rb, logic [7:0] db,
				logic s);
			i2cmw_pkg::res_t r;
			logic done;
			done = 1'b0;
			if (phase == i2cmw_pkg::PH_IDLE) begin
				if (g) begin
					mode      = o;
					held_reg  = rb;
					held_data = db;
					shifter   = addr_cfg;
					byte_sel  = i2cmw_pkg::BYTE_ADDR;
					bit_cnt   = 3'd0;
					nack_hit  = 1'b0;
					phase     = i2cmw_pkg::PH_START;
					beat      = 2'd0;
					scl       = 1'b1;
					sda       = 1'b1;
					tick_cnt  = 16'd1;
				end
			end else if (tick_cnt < phase_len()) begin
				tick_cnt = tick_cnt + 16'd1;
			end else begin
				tick_cnt = 16'd1;
				advance_phase(s, done);
			end
			r.scl_out     = scl;
			r.sda_out     = sda;
			r.busy_res    = (phase != i2cmw_pkg::PH_IDLE);
			r.done_res    = done;
			r.nack        = done && nack_hit;
			r.failed_byte = (done && nack_hit) ? byte_sel : 2'd0;
			bus_levels_q.push_back(r);
		endfunction

		function void check_result(i2cmw_pkg::res_t got);
			i2cmw_pkg::res_t want;
			if (bus_levels_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with nothing expected: %p", got);
				return;
			end
			want = bus_levels_q.pop_front();
			if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
			    got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
			    got.nack !== want.nack || got.failed_byte !== want.failed_byte) begin
				errors++;
				if (errors <= 10)
					$display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [i2cmw_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [i2cmw_pkg::CFG_DATA_W-1:0]  cfg_data;

	i2cmw_item_if item_if();
	i2cmw_res_if  res_if();

	i2c_master_register_write_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	i2c_bus_scoreboard sb = new;
	bit                fast_tx = 1'b0;
	logic [1:0]        nack_at = NO_NACK;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_tick(input i2cmw_pkg::op_t o, input logic g, input logic [7:0] rb,
			input logic [7:0] db, input logic s);
		int gap;
		gap = fast_tx ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid     <= 1'b1;
		item_if.op        <= o;
		item_if.go        <= g;
		item_if.reg_byte  <= rb;
		item_if.data_byte <= db;
		item_if.sda_in    <= s;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		sb.note_tick(o, g, rb, db, s);
	endtask

	// One random tick; acknowledges follow the nack plan but for rare noisy ones.
	task automatic random_tick(input int go_pct, input bit noisy);
		i2cmw_pkg::op_t o;
		logic       g;
		logic       s;
		logic [7:0] rb;
		logic [7:0] db;
		int         r;
		o  = i2cmw_pkg::op_t'($urandom_range(0, 1));
		rb = 8'($urandom_range(0, 255));
		db = 8'($urandom_range(0, 255));
		s  = 1'($urandom_range(0, 1));
		if (sb.idle()) begin
			g = ($urandom_range(0, 99) < go_pct);
			if (g) begin
				o = ($urandom_range(0, 3) == 0) ? i2cmw_pkg::OP_PROBE : i2cmw_pkg::OP_WRITE;
				r = $urandom_range(0, 9);
				if (r < 6)
					nack_at = NO_NACK;
				else if (r < 8)
					nack_at = i2cmw_pkg::BYTE_ADDR;
				else if (r == 8)
					nack_at = i2cmw_pkg::BYTE_REG;
				else
					nack_at = i2cmw_pkg::BYTE_DATA;
			end
		end else if (sb.done_next()) begin
			g = 1'($urandom_range(0, 1));
		end else begin
			g = ($urandom_range(0, 15) == 0);
		end
		if (sb.ack_next() && !(noisy && $urandom_range(0, 19) == 0))
			s = (sb.byte_sel == nack_at);
		send_tick(o, g, rb, db, s);
	endtask

	task automatic start_txn(input i2cmw_pkg::op_t o, input logic [7:0] rb,
			input logic [7:0] db, input logic [1:0] plan);
		nack_at = plan;
		send_tick(o, 1'b1, rb, db, 1'($urandom_range(0, 1)));
		while (!sb.idle()) random_tick(0, 1'b0);
	endtask

	task automatic random_run(input int n);
		repeat (n) random_tick(8, 1'b1);
		while (!sb.idle()) random_tick(0, 1'b1);
	endtask

	task automatic set_reg(input i2cmw_pkg::cfg_reg_t idx, input logic [15:0] v);
		item_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, v);
	endtask

	initial begin : stimulus
		logic [7:0]  run_addr[4];
		logic [15:0] run_ticks[4];
		int          run_len[4];
		run_addr          = '{8'h00, 8'hA5, 8'h5A, 8'hFF};
		run_ticks         = '{16'd1, 16'd2, 16'd3, 16'd1};
		run_len           = '{80, 70, 70, 70};
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= i2cmw_pkg::REG_ADDRESS_BYTE;
		cfg_data          <= '0;
		item_if.valid     <= 1'b0;
		item_if.op        <= i2cmw_pkg::OP_WRITE;
		item_if.go        <= 1'b0;
		item_if.reg_byte  <= '0;
		item_if.data_byte <= '0;
		item_if.sda_in    <= 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: address byte 120, 90 ticks per phase step; the rest of the
		// transaction then runs at one tick per step
		nack_at = i2cmw_pkg::BYTE_ADDR;
		send_tick(i2cmw_pkg::OP_WRITE, 1'b1, 8'hFF, 8'h00, 1'b0);
		repeat (200) random_tick(0, 1'b0);
		set_reg(i2cmw_pkg::REG_PHASE_TICKS, 16'd1);
		while (!sb.idle()) random_tick(0, 1'b0);

		// zero phase length behaves as one tick
		set_reg(i2cmw_pkg::REG_PHASE_TICKS, 16'd0);
		set_reg(i2cmw_pkg::REG_ADDRESS_BYTE, 16'h00FF);
		start_txn(i2cmw_pkg::OP_WRITE, 8'hFF, 8'h00, NO_NACK);
		start_txn(i2cmw_pkg::OP_WRITE, 8'h00, 8'hFF, i2cmw_pkg::BYTE_DATA);
		start_txn(i2cmw_pkg::OP_WRITE, 8'hA5, 8'h5A, i2cmw_pkg::BYTE_REG);
		start_txn(i2cmw_pkg::OP_PROBE, 8'h3C, 8'hC3, NO_NACK);
		start_txn(i2cmw_pkg::OP_PROBE, 8'hFF, 8'hFF, i2cmw_pkg::BYTE_ADDR);

		set_reg(i2cmw_pkg::REG_ADDRESS_BYTE, 16'h0000);
		set_reg(i2cmw_pkg::REG_PHASE_TICKS, 16'd1);
		start_txn(i2cmw_pkg::OP_WRITE, 8'h81, 8'h7E, NO_NACK);
		start_txn(i2cmw_pkg::OP_WRITE, 8'h00, 8'h00, i2cmw_pkg::BYTE_ADDR);

		for (int i = 0; i < 4; i++) begin
			set_reg(i2cmw_pkg::REG_ADDRESS_BYTE, {8'h00, run_addr[i]});
			set_reg(i2cmw_pkg::REG_PHASE_TICKS, run_ticks[i]);
			fast_tx = (i == 3);
			random_run(run_len[i]);
		end
		fast_tx = 1'b0;

		// longest phase: only the counting is seen before the run ends
		set_reg(i2cmw_pkg::REG_PHASE_TICKS, 16'hFFFF);
		set_reg(i2cmw_pkg::REG_ADDRESS_BYTE, 16'h003C);
		start_txn_partial: begin
			nack_at = NO_NACK;
			send_tick(i2cmw_pkg::OP_WRITE, 1'b1, 8'h12, 8'h34, 1'b0);
			repeat (60) random_tick(0, 1'b1);
		end
		item_if.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin : result_side
		int   stall;
		int   taken;
		i2cmw_pkg::res_t got;
		taken = 0;
		forever begin
			if (taken == 400)
				stall = 150;
			else if ((taken / 64) % 4 == 3)
				stall = 0;
			else
				stall = $urandom_range(0, 11);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
			got.scl_out     = res_if.scl_out;
			got.sda_out     = res_if.sda_out;
			got.busy_res    = res_if.busy_res;
			got.done_res    = res_if.done_res;
			got.nack        = res_if.nack;
			got.failed_byte = res_if.failed_byte;
			sb.check_result(got);
			taken++;
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

[filelist.f]
hdl/i2cmw_pkg.sv
hdl/i2cmw_item_if.sv
hdl/i2cmw_res_if.sv
hdl/i2c_master_register_write_core.sv
hdl/i2cmw_checker.sv
bench/testbench.sv
